@@ hdl/four_level_page_table_mapper_macros.svh @@
// Assertion shorthands used by the mapper walk RTL.
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptm assertion failed");

// Next-cycle implication, disabled in reset.
`define PTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptm assertion failed");

`endif

@@ hdl/ptm_pkg.sv @@
package ptm_pkg;

  localparam int IDX_BITS      = 9;
  localparam int VA_BITS       = 48;
  localparam int PA_BITS       = 52;
  localparam int PAGE_BITS     = 12;
  localparam int SCRATCH_BITS  = 40;
  localparam int SCRATCH_COUNT = 3;
  localparam int TOP_SLOT      = 3;
  localparam int LEVEL_SHIFT0  = 39;
  localparam int LEVEL_SHIFT1  = 30;
  localparam int LEVEL_SHIFT2  = 21;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_VA_MISALIGN = 3'd1,
    ST_PA_MISALIGN = 3'd2,
    ST_NO_TABLES   = 3'd3,
    ST_UNMAP_SKIP  = 3'd4
  } result_code_t;

  typedef enum logic [0:0] {
    ACT_MAP   = 1'b0,
    ACT_UNMAP = 1'b1
  } action_t;

  typedef struct packed {
    logic                 action;
    logic [VA_BITS-1:0]   virtual_address;
    logic [PA_BITS-1:0]   physical_address;
    logic                 last_page;
  } in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [PA_BITS-1:0]   leaf_entry;
    logic [6:0]           tables_in_use;
    logic                 last_result;
  } out_t;

endpackage

@@ hdl/four_level_page_table_mapper.sv @@
// Maps or unmaps one 4 KiB page per transaction in a four-level page table.
// After reset the block sweeps its table memory clear, one entry per cycle,
// with busy high; configuration writes are still taken. A page that passes
// the alignment checks is accepted while idle, then takes a read and an
// evaluate state for each of the three pointer levels, bounded by the
// single-port table memory with its registered read. A rejected address or
// a stopped walk returns sooner. Each result is shown on out_data for one
// cycle with out_strobe high; the receiver cannot stall it, so it must take
// every strobe. Write scratch_page only while idle.
module four_level_page_table_mapper import ptm_pkg::*; #(
  parameter int TABLE_SLOTS    = 64,
  parameter int PHYS_ADDR_BITS = 52
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  in_t                     in_data,
  output logic                    out_strobe,
  output out_t                    out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SCRATCH_BITS-1:0] cfg_data
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int AW = SW + IDX_BITS;

  logic [SCRATCH_BITS-1:0] scratch_r, scratch_nxt;
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_addr;
  logic [SW-1:0]           mem_wdata, mem_rdata;

  assign cfg_ready   = 1'b1;
  assign scratch_nxt = (cfg_valid && cfg_ready) ? cfg_data : scratch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scratch_r <= '0;
    end else begin
      scratch_r <= scratch_nxt;
    end
  end

  ptm_walk #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .scratch_page(scratch_r),
    .out_strobe  (out_strobe),
    .out_data    (out_data),
    .mem_we      (mem_we),
    .mem_re      (mem_re),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata)
  );

  ptm_store #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

@@ hdl/ptm_store.sv @@
module ptm_store import ptm_pkg::*; #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic                                      re,
  input  logic [$clog2(TABLE_SLOTS)+IDX_BITS-1:0]   addr,
  input  logic [$clog2(TABLE_SLOTS)-1:0]            wdata,
  output logic [$clog2(TABLE_SLOTS)-1:0]            rdata
);

  localparam int SW    = $clog2(TABLE_SLOTS);
  localparam int DEPTH = TABLE_SLOTS * (2 ** IDX_BITS);

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/ptm_walk.sv @@
`include "four_level_page_table_mapper_macros.svh"
module ptm_walk import ptm_pkg::*; #(
  parameter int TABLE_SLOTS    = 64,
  parameter int PHYS_ADDR_BITS = 52
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  output logic                                      busy,
  input  in_t                                       in_data,
  input  logic [SCRATCH_BITS-1:0]                   scratch_page,
  output logic                                      out_strobe,
  output out_t                                      out_data,
  output logic                                      mem_we,
  output logic                                      mem_re,
  output logic [$clog2(TABLE_SLOTS)+IDX_BITS-1:0]   mem_addr,
  output logic [$clog2(TABLE_SLOTS)-1:0]            mem_wdata,
  input  logic [$clog2(TABLE_SLOTS)-1:0]            mem_rdata
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int AW = SW + IDX_BITS;
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EVAL  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [CW-1:0]      slots_r, slots_nxt;
  logic [SW-1:0]      table_r, table_nxt;
  logic [1:0]         level_r, level_nxt;
  in_t                item_r, item_nxt;
  logic               strobe_r, strobe_nxt;
  out_t               res_r, res_nxt;
  logic [IDX_BITS-1:0] idx;
  logic [CW+6:0]      slots_ext;
  logic [PA_BITS-1:0] leaf;
  logic               pa_bad;

  always_comb begin
    case (level_r)
      2'd0:    idx = item_r.virtual_address[LEVEL_SHIFT0 +: IDX_BITS];
      2'd1:    idx = item_r.virtual_address[LEVEL_SHIFT1 +: IDX_BITS];
      default: idx = item_r.virtual_address[LEVEL_SHIFT2 +: IDX_BITS];
    endcase
  end

  assign pa_bad = (in_data.physical_address[PAGE_BITS-1:0] != '0) ||
                  ((in_data.physical_address >> PHYS_ADDR_BITS) != '0);

  always_comb begin
    clr_nxt    = clr_r;
    slots_nxt  = slots_r;
    table_nxt  = table_r;
    level_nxt  = level_r;
    item_nxt   = item_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    state_nxt  = state_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = {table_r, idx};
    mem_wdata  = '0;
    slots_ext  = {7'd0, slots_r};
    leaf       = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          table_nxt = SW'(TOP_SLOT);
          level_nxt = 2'd0;
          res_nxt.last_result   = in_data.last_page;
          res_nxt.leaf_entry    = '0;
          res_nxt.tables_in_use = slots_ext[6:0];
          if (in_data.virtual_address[PAGE_BITS-1:0] != '0) begin
            res_nxt.status = ST_VA_MISALIGN;
            strobe_nxt     = 1'b1;
          end else if (in_data.action == ACT_MAP && pa_bad) begin
            res_nxt.status = ST_PA_MISALIGN;
            strobe_nxt     = 1'b1;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (mem_rdata < SW'(SCRATCH_COUNT)) begin
          if (item_r.action == ACT_UNMAP) begin
            res_nxt.status = ST_UNMAP_SKIP;
            strobe_nxt     = 1'b1;
            state_nxt      = S_IDLE;
          end else if (slots_r >= CW'(TABLE_SLOTS)) begin
            res_nxt.status = ST_NO_TABLES;
            strobe_nxt     = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            // Take a fresh slot: it reads as scratch since the clear pass.
            mem_we    = 1'b1;
            mem_wdata = slots_r[SW-1:0];
            table_nxt = slots_r[SW-1:0];
            slots_nxt = slots_r + CW'(1);
            state_nxt = S_READ;
          end
        end else begin
          table_nxt = mem_rdata;
          state_nxt = S_READ;
        end
        slots_ext = {7'd0, slots_nxt};
        res_nxt.tables_in_use = slots_ext[6:0];
        if (state_nxt == S_READ) begin
          level_nxt = level_r + 2'd1;
          if (level_r == 2'd2) begin
            if (item_r.action == ACT_UNMAP) begin
              leaf = {scratch_page, {PAGE_BITS{1'b0}}} | PA_BITS'(3);
            end else begin
              leaf = item_r.physical_address | PA_BITS'(3);
            end
            res_nxt.status     = ST_OK;
            res_nxt.leaf_entry = leaf;
            strobe_nxt         = 1'b1;
            state_nxt          = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      slots_r  <= CW'(4);
      strobe_r <= 1'b0;
      level_r  <= 2'd0;
      table_r  <= SW'(TOP_SLOT);
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      slots_r  <= slots_nxt;
      strobe_r <= strobe_nxt;
      level_r  <= level_nxt;
      table_r  <= table_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_data   = res_r;

  `PTM_ASSERT_IMP(a_no_rw_clash, clk, rst_n, mem_we, !mem_re)
  `PTM_ASSERT_IMP(a_slots_bound, clk, rst_n, 1'b1, slots_r <= CW'(TABLE_SLOTS))
  `PTM_ASSERT_IMP(a_strobe_idle, clk, rst_n, strobe_r, state_r == S_IDLE)
  `PTM_ASSERT_NEXT(a_read_then_eval, clk, rst_n, mem_re, state_r == S_EVAL)

endmodule

@@ tb/four_level_page_table_mapper_tb.sv @@
module four_level_page_table_mapper_tb;
  import ptm_pkg::*;

  localparam int SLOTS = 64;
  localparam int ENTRIES = 512;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  in_t                     in_data;
  logic                    out_strobe;
  out_t                    out_data;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [SCRATCH_BITS-1:0] cfg_data;

  four_level_page_table_mapper #(
    .TABLE_SLOTS   (SLOTS),
    .PHYS_ADDR_BITS(PA_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow page table: pointer entries only, leaf entries are never read back.
  logic [6:0]              child_slot [SLOTS][ENTRIES];
  int                      slots_used;
  logic [SCRATCH_BITS-1:0] scratch_pfn;

  in_t  page_q[$];
  out_t leaf_q[$];
  int   idle_pct;
  int   errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  function automatic out_t walk_page(in_t pg);
    out_t                r;
    int                  tbl;
    int                  kid;
    int                  fresh;
    logic [IDX_BITS-1:0] idx;
    int                  shift [3];
    shift = '{LEVEL_SHIFT0, LEVEL_SHIFT1, LEVEL_SHIFT2};
    r = '0;
    r.status = ST_OK;
    tbl = TOP_SLOT;
    if (pg.virtual_address[PAGE_BITS-1:0] != 0) begin
      r.status = ST_VA_MISALIGN;
    end else if (pg.action == ACT_MAP && pg.physical_address[PAGE_BITS-1:0] != 0) begin
      r.status = ST_PA_MISALIGN;
    end else begin
      for (int lvl = 0; lvl < 3; lvl++) begin
        idx = IDX_BITS'(pg.virtual_address >> shift[lvl]);
        kid = int'(child_slot[tbl][idx]);
        if (kid < SCRATCH_COUNT) begin
          if (pg.action == ACT_UNMAP) begin
            r.status = ST_UNMAP_SKIP;
            break;
          end
          if (slots_used >= SLOTS) begin
            r.status = ST_NO_TABLES;
            break;
          end
          fresh = slots_used;
          slots_used++;
          child_slot[fresh] = child_slot[kid];
          child_slot[tbl][idx] = 7'(fresh);
          kid = fresh;
        end
        tbl = kid;
      end
      if (r.status == ST_OK) begin
        if (pg.action == ACT_UNMAP) r.leaf_entry = {scratch_pfn, 12'h003};
        else r.leaf_entry = pg.physical_address | 52'h3;
      end
    end
    r.tables_in_use = slots_used[6:0];
    r.last_result = pg.last_page;
    return r;
  endfunction

  function automatic in_t mk_page(action_t act, logic [VA_BITS-1:0] va,
                                  logic [PA_BITS-1:0] pa);
    in_t p;
    p.action = act;
    p.virtual_address = va;
    p.physical_address = pa;
    p.last_page = 1'($urandom_range(0, 1));
    return p;
  endfunction

  // Most addresses come from a small set of upper indices so walks reuse tables.
  function automatic in_t rand_page();
    logic [IDX_BITS-1:0] i0, i1, i2, i3;
    logic [VA_BITS-1:0]  va;
    logic [PA_BITS-1:0]  pa;
    action_t             act;
    int                  roll;
    i0 = $urandom_range(0, 1) ? '1 : '0;
    i1 = $urandom_range(0, 1) ? '1 : '0;
    i2 = $urandom_range(0, 1) ? '1 : '0;
    i3 = IDX_BITS'($urandom);
    va = {i0, i1, i2, i3, 12'h000};
    pa = {SCRATCH_BITS'({$urandom, $urandom}), 12'h000};
    act = ($urandom_range(0, 99) < 60) ? ACT_MAP : ACT_UNMAP;
    roll = $urandom_range(0, 99);
    if (roll < 8) va = {36'({$urandom, $urandom}), 12'h000};
    else if (roll < 13) va[PAGE_BITS-1:0] = PAGE_BITS'($urandom_range(1, 4095));
    else if (roll < 18) pa[PAGE_BITS-1:0] = PAGE_BITS'($urandom_range(1, 4095));
    return mk_page(act, va, pa);
  endfunction

  // Driver: hold start until the transaction is taken, then maybe idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) leaf_q.push_back(walk_page(in_data));
      if (!start || !busy) begin
        if (page_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data <= page_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h got %h", name, exp_v, act_v);
    end
  endtask

  // Monitor: every strobe is one result transaction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (leaf_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        check_field("status", 64'(leaf_q[0].status), 64'(out_data.status));
        check_field("leaf_entry", 64'(leaf_q[0].leaf_entry), 64'(out_data.leaf_entry));
        check_field("tables_in_use", 64'(leaf_q[0].tables_in_use),
                    64'(out_data.tables_in_use));
        check_field("last_result", 64'(leaf_q[0].last_result),
                    64'(out_data.last_result));
        void'(leaf_q.pop_front());
      end
    end
  end

  task automatic write_scratch(logic [SCRATCH_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    scratch_pfn = v;
  endtask

  task automatic drain();
    do @(posedge clk); while (page_q.size() > 0 || start || leaf_q.size() > 0);
  endtask

  initial begin
    int                      pcts [4];
    logic [SCRATCH_BITS-1:0] scr  [4];
    pcts = '{0, 52, 15, 0};
    scr = '{40'hFF_FFFF_FFFF, 40'h0, 40'h0, 40'h0};
    scr[2] = SCRATCH_BITS'({$urandom, $urandom});
    scr[3] = SCRATCH_BITS'({$urandom, $urandom});
    errors = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    scratch_pfn = '0;
    slots_used = 4;
    for (int e = 0; e < ENTRIES; e++) begin
      child_slot[0][e] = 7'd0;
      child_slot[1][e] = 7'd0;
      child_slot[2][e] = 7'd1;
      child_slot[TOP_SLOT][e] = 7'd2;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      write_scratch(scr[ph]);
      idle_pct = pcts[ph];
      if (ph == 0) begin
        page_q.push_back(mk_page(ACT_MAP, 48'h0000_0000_0001, 52'h0));
        page_q.push_back(mk_page(ACT_UNMAP, 48'hFFFF_FFFF_F800, 52'h0));
        page_q.push_back(mk_page(ACT_MAP, 48'h0, 52'h0_0000_0000_0001));
        page_q.push_back(mk_page(ACT_MAP, 48'h0, 52'hF_FFFF_FFFF_FFFF));
        page_q.push_back(mk_page(ACT_UNMAP, 48'h0, 52'h0));
        page_q.push_back(mk_page(ACT_UNMAP, 48'h1234_5678_9000, 52'h0));
        page_q.push_back(mk_page(ACT_MAP, 48'h0, 52'h0));
        page_q.push_back(mk_page(ACT_MAP, 48'hFFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000));
        page_q.push_back(mk_page(ACT_MAP, 48'hFFFF_FFFF_E000, 52'hA_5A5A_5A5A_5000));
        page_q.push_back(mk_page(ACT_UNMAP, 48'hFFFF_FFFF_F000, 52'h0_0000_0000_0FFF));
        page_q.push_back(mk_page(ACT_MAP, 48'hFFFF_FFFF_F000, 52'h5_A5A5_A5A5_A000));
        page_q.push_back(mk_page(ACT_UNMAP, 48'h0, 52'h0));
        page_q.push_back(mk_page(ACT_MAP, 48'h0000_0000_1000, 52'h0_0000_0000_1000));
        page_q.push_back(mk_page(ACT_MAP, 48'h0, 52'hF_FFFF_FFFF_F800));
        page_q.push_back(mk_page(ACT_UNMAP, 48'h0000_0000_0FFF, 52'h0));
        drain();
      end
      repeat (120) page_q.push_back(rand_page());
      drain();
    end
    repeat (20) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
